FILE: rtl/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, ck, rs, ante, cons, msg)
`define ASSERT_NEXT(lbl, ck, rs, ante, cons, msg)
`endif
`endif

FILE: rtl/gphp_pkg.sv
`default_nettype none
package gphp_pkg;

  localparam int MAX_EVENTS = 8;
  localparam int SLOT_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int CNT_W = $clog2(MAX_EVENTS + 1);
  localparam int ACC_W = 32 + $clog2(MAX_EVENTS + 2);
  localparam int EXP_INT_LEN = 24;
  localparam int EXP_FRAC_LEN = 64;
  localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

  typedef enum logic [1:0] {
    REG_Q_CENTER = 2'd0,
    REG_Q_WIDTH  = 2'd1,
    REG_Q_PEAK   = 2'd2,
    REG_ACTIVE   = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_EVAL = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic        req_type;
    logic [2:0]  event_slot;
    logic signed [31:0] event_center;
    logic [31:0] event_width;
    logic [31:0] event_peak;
    logic [31:0] rise_begin;
    logic [31:0] rise_finish;
    logic [31:0] decay_begin;
    logic [31:0] decay_finish;
    logic signed [31:0] position;
    logic [31:0] sample_time;
  } req_t;

  typedef struct packed {
    logic [31:0] heating_rate;
    logic        saturated;
  } rsp_t;

  typedef struct packed {
    logic [31:0] center;
    logic [31:0] width;
    logic [31:0] peak;
    logic [31:0] rise_begin;
    logic [31:0] rise_finish;
    logic [31:0] decay_begin;
    logic [31:0] decay_finish;
  } slot_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

  typedef logic [EXP_FRAC_LEN-1:0][31:0] efrac_t;
  typedef logic [EXP_INT_LEN-1:0][31:0] eint_t;

  // Truncated eleven-term series for e^-y, y in Q1.31.
  function automatic logic [63:0] exp_series(input logic [63:0] y);
    logic [63:0] sum;
    logic [63:0] term;
    sum = 64'(ONE_Q31);
    term = 64'(ONE_Q31);
    for (int k = 1; k <= 10; k++) begin
      term = ((term * y) >> 31) / 64'(k);
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic efrac_t build_efrac();
    efrac_t tab;
    tab[0] = ONE_Q31;
    for (int j = 1; j < EXP_FRAC_LEN; j++) begin
      tab[j] = 32'(exp_series(64'(j) << 25));
    end
    return tab;
  endfunction

  localparam efrac_t EFRAC = build_efrac();

  function automatic eint_t build_eint();
    eint_t tab;
    logic [63:0] e1;
    logic [63:0] v;
    e1 = (64'(EFRAC[63]) * 64'(EFRAC[1])) >> 31;
    v = 64'(ONE_Q31);
    tab[0] = ONE_Q31;
    for (int n = 1; n < EXP_INT_LEN; n++) begin
      v = (v * e1) >> 31;
      tab[n] = 32'(v);
    end
    return tab;
  endfunction

  localparam eint_t EINT = build_eint();

endpackage
`default_nettype wire

FILE: rtl/gaussian_pulse_heating_profile.sv
`default_nettype none
// Heating-rate evaluator with a steady Gaussian term and a table of events.
// The req channel takes one word per item. A load word writes its event
// into a table slot and gives no rsp word. An evaluate word gives one
// rsp word with the summed rate, saturated and flagged.
// Configuration is written through cfg_we, cfg_index and cfg_data; the
// user writes it only while the block is idle, which the block does not enforce.
// An evaluation walks the steady term, if its peak is nonzero, and then
// each active slot in turn. A slot inside a ramp phase first runs the
// shared restoring divider for the envelope; each term whose distance
// from its centre is below eight widths then runs it for the Gaussian
// ratio. A slot outside its time window skips both divisions.
// A new req word is taken only when the previous item is finished; the
// rsp word sits in an output register, so the next req word is taken
// while it waits for rsp_ready. If an earlier rsp word still waits, the
// finished sum holds until that one is taken.
// Reset clears the control state and loads the register reset values; the
// event table holds no data until loaded.
module gaussian_pulse_heating_profile import gphp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire req_t        req,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output rsp_t             rsp,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

`include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_SLOT, S_ENV, S_ENVDIV, S_GCHK, S_GDIV, S_SQ,
    S_EXPA, S_EXPB, S_PK, S_ENVMUL, S_NEXT, S_OUT
  } state_t;

  state_t state;

  logic signed [31:0] q_center;
  logic [31:0] q_width;
  logic [31:0] q_peak;
  logic [3:0]  active;

  logic signed [31:0] pos;
  logic [31:0] t;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] n_slots;
  logic        q_phase;
  logic        env_fall;
  logic [31:0] cur_ctr;
  logic [31:0] cur_w;
  logic [31:0] cur_pk;
  logic [31:0] env;
  logic [26:0] r;
  logic [20:0] x;
  logic [31:0] a;
  logic [31:0] rem;
  logic [31:0] gval;
  logic [31:0] c;
  logic [ACC_W-1:0] acc;

  slot_t       rd;
  slot_t       wr;
  logic        ram_we;
  div_req_t    dreq;
  div_rsp_t    drsp;

  logic signed [32:0] diff;
  logic [32:0] dabs;
  logic [31:0] d;
  logic [63:0] prod_rr;
  logic [63:0] prod_a;
  logic [24:0] g31;
  logic [49:0] gsq;
  logic [63:0] prod_g;
  logic [63:0] prod_c;
  logic [63:0] prod_e;

  always_comb begin
    wr.center = req.event_center;
    wr.width = req.event_width;
    wr.peak = req.event_peak;
    wr.rise_begin = req.rise_begin;
    wr.rise_finish = req.rise_finish;
    wr.decay_begin = req.decay_begin;
    wr.decay_finish = req.decay_finish;
  end

  assign req_ready = (state == S_IDLE);
  assign ram_we = req_valid && req_ready && (req.req_type == REQ_LOAD) &&
                  (32'(req.event_slot) < 32'(MAX_EVENTS));

  gphp_ram #(.WIDTH($bits(slot_t)), .DEPTH(MAX_EVENTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (SLOT_W'(req.event_slot)),
    .wdata (wr),
    .raddr (idx[SLOT_W-1:0]),
    .rdata (rd)
  );

  gphp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // Divider operands are chosen by the state that starts it.
  always_comb begin
    dreq.start = 1'b0;
    dreq.num = {8'd0, d, 24'd0};
    dreq.den = cur_w;
    if (state == S_ENV) begin
      if (t >= rd.rise_begin && t <= rd.decay_finish) begin
        if (t <= rd.rise_finish) begin
          dreq.start = (rd.rise_finish != rd.rise_begin);
          dreq.num = {1'b0, 32'(t - rd.rise_begin), 31'd0};
          dreq.den = rd.rise_finish - rd.rise_begin;
        end else if (t >= rd.decay_begin) begin
          dreq.start = (rd.decay_finish != rd.decay_begin);
          dreq.num = {1'b0, 32'(t - rd.decay_begin), 31'd0};
          dreq.den = rd.decay_finish - rd.decay_begin;
        end
      end
    end else if (state == S_GCHK) begin
      dreq.start = (cur_w != 32'd0) && ({1'b0, d} < {cur_w, 3'b000});
    end
  end

  assign diff = {pos[31], pos} - {cur_ctr[31], cur_ctr};
  assign dabs = diff[32] ? 33'(-diff) : 33'(diff);
  assign d = dabs[31:0];
  assign prod_rr = 64'(r) * 64'(r);
  assign prod_a = 64'(EINT[x[20:16]]) * 64'(EFRAC[x[15:10]]);
  assign g31 = {x[9:0], 15'd0};
  assign gsq = 50'(g31) * 50'(g31);
  assign prod_g = 64'(a) * 64'(rem);
  assign prod_c = 64'(cur_pk) * 64'(gval);
  assign prod_e = 64'(c) * 64'(env);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp_valid <= 1'b0;
      q_center <= '0;
      q_width <= 32'd65536;
      q_peak <= '0;
      active <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_Q_CENTER: q_center <= cfg_data;
          REG_Q_WIDTH:  q_width <= cfg_data;
          REG_Q_PEAK:   q_peak <= cfg_data;
          REG_ACTIVE:   active <= cfg_data[3:0];
          default: ;
        endcase
      end
      // In the output step the new word takes the place of the one leaving.
      if (rsp_valid && rsp_ready && state != S_OUT) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid && req.req_type == REQ_EVAL) begin
            pos <= req.position;
            t <= req.sample_time;
            idx <= '0;
            acc <= '0;
            n_slots <= (32'(active) < 32'(MAX_EVENTS)) ? CNT_W'(active)
                                                       : CNT_W'(MAX_EVENTS);
            cur_ctr <= q_center;
            cur_w <= q_width;
            cur_pk <= q_peak;
            env <= ONE_Q31;
            q_phase <= (q_peak != 32'd0);
            state <= (q_peak != 32'd0) ? S_GCHK : S_SLOT;
          end
        end
        S_SLOT: begin
          state <= (idx < n_slots) ? S_ENV : S_OUT;
        end
        S_ENV: begin
          cur_ctr <= rd.center;
          cur_w <= rd.width;
          cur_pk <= rd.peak;
          env <= ONE_Q31;
          if (t < rd.rise_begin || t > rd.decay_finish) begin
            state <= S_NEXT;
          end else if (dreq.start) begin
            env_fall <= (t > rd.rise_finish);
            state <= S_ENVDIV;
          end else begin
            state <= S_GCHK;
          end
        end
        S_ENVDIV: begin
          if (drsp.done) begin
            env <= env_fall ? ONE_Q31 - drsp.quo : drsp.quo;
            state <= S_GCHK;
          end
        end
        S_GCHK: begin
          state <= dreq.start ? S_GDIV : S_NEXT;
        end
        S_GDIV: begin
          if (drsp.done) begin
            r <= drsp.quo[26:0];
            state <= S_SQ;
          end
        end
        S_SQ: begin
          x <= prod_rr[53:33];
          state <= S_EXPA;
        end
        S_EXPA: begin
          a <= prod_a[62:31];
          rem <= ONE_Q31 - 32'(g31) + 32'(gsq[49:32]);
          state <= (x[20:16] >= 5'(EXP_INT_LEN)) ? S_NEXT : S_EXPB;
        end
        S_EXPB: begin
          gval <= prod_g[62:31];
          state <= S_PK;
        end
        S_PK: begin
          c <= prod_c[62:31];
          state <= S_ENVMUL;
        end
        S_ENVMUL: begin
          acc <= acc + ACC_W'(prod_e[63:31]);
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (q_phase) begin
            q_phase <= 1'b0;
          end else begin
            idx <= idx + CNT_W'(1);
          end
          state <= S_SLOT;
        end
        S_OUT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            if (acc > ACC_W'(32'hFFFF_FFFF)) begin
              rsp.heating_rate <= 32'hFFFF_FFFF;
              rsp.saturated <= 1'b1;
            end else begin
              rsp.heating_rate <= acc[31:0];
              rsp.saturated <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_div_owner, clk, rst, drsp.busy,
                  state == S_ENVDIV || state == S_GDIV, "divider busy outside a wait")
  `ASSERT_IMPLIES(a_rsp_source, clk, rst, $rose(rsp_valid),
                  $past(state) == S_OUT, "rsp word raised outside output step")
  `ASSERT_NEXT(a_load_silent, clk, rst, ram_we,
               state == S_IDLE && !$rose(rsp_valid), "load word caused work")

endmodule
`default_nettype wire

FILE: rtl/gphp_ram.sv
`default_nettype none
module gphp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/gphp_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle. The caller guarantees
// that the quotient fits in 32 bits (upper numerator word below divisor).
module gphp_div import gphp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] den;
  logic [32:0] shifted;
  logic        fits;

  assign shifted = {rem, quo[31]};
  assign fits = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt <= '0;
        rem <= req.num[63:32];
        quo <= req.num[31:0];
        den <= req.den;
      end else if (busy) begin
        rem <= fits ? 32'(shifted - {1'b0, den}) : shifted[31:0];
        quo <= {quo[30:0], fits};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo = quo;

endmodule
`default_nettype wire
